FILE: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WORD_W = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS = 64;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic       put_byte;     // write byte (or pad byte) at byte position
        logic       use_pad;      // byte is 0x80 instead of input byte
        logic       clear_tail;   // zero words above the pad position
        logic       clear_all;    // zero whole block
        logic       put_length;   // write bit length into words 14,15
        logic       add_block;    // message_bits += 512
        logic       comp_start;   // load working vars, round 0
        logic       comp_round;   // run one round
        logic       comp_final;   // add working vars into hash
        logic       init_hash;    // restart message
        logic       out_shift;    // advance digest output
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       round_last;
    } sha_status_t;

    function automatic logic [31:0] sha_k(input logic [5:0] r);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[r];
    endfunction

    function automatic logic [31:0] sha_iv(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: design/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256_in_if / sha256_out_if
// Valid/ready channels for message items and digest words
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] message_byte;
    modport source (output valid, output command, output message_byte, input ready);
    modport sink (input valid, input command, input message_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

FILE: design/sha256_datapath.sv
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer, message schedule window, round unit and chaining state
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha256_pkg::sha_cmd_t     cmd,
    input  logic [7:0]               in_byte,
    output sha256_pkg::sha_status_t  status,
    output logic [31:0]              digest_word
);
    import sha256_pkg::*;

    logic [31:0] w_reg [0:15];
    logic [31:0] w_next [0:15];
    logic [31:0] h_reg [0:7];
    logic [31:0] h_next [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] v_next [0:7];
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;

    logic [31:0] t1, t2, s0, s1, wnew, e, a;
    logic [63:0] total;
    logic [7:0]  b;
    logic [3:0]  widx;
    logic [1:0]  lane;

    assign status.pos = pos_reg;
    assign status.round_last = (rnd_reg == 6'd63);
    assign digest_word = h_reg[0];

    assign total = bits_reg + {55'd0, pos_reg, 3'd0};
    assign b = cmd.use_pad ? 8'h80 : in_byte;
    assign widx = pos_reg[5:2];
    assign lane = pos_reg[1:0];

    assign e = v_reg[4];
    assign a = v_reg[0];
    assign t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_k(rnd_reg) + w_reg[0];
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    // schedule window: w_reg[0] is the word of the current round
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];

    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        v_next = v_reg;
        pos_next = pos_reg;
        bits_next = bits_reg;
        rnd_next = rnd_reg;
        if (cmd.put_byte)
        begin
            unique case (lane)
                2'd0: w_next[widx] = {b, 24'd0};
                2'd1: w_next[widx] = {w_reg[widx][31:24], b, 16'd0};
                2'd2: w_next[widx] = {w_reg[widx][31:16], b, 8'd0};
                default: w_next[widx] = {w_reg[widx][31:8], b};
            endcase
            // the pad byte leaves pos at the tail length for the length words
            if (!cmd.use_pad)
                pos_next = pos_reg + 6'd1;
        end
        if (cmd.clear_tail)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) > widx)
                    w_next[i] = '0;
            end
        end
        if (cmd.clear_all)
        begin
            for (int i = 0; i < 16; i++)
                w_next[i] = '0;
        end
        if (cmd.put_length)
        begin
            w_next[14] = total[63:32];
            w_next[15] = total[31:0];
        end
        if (cmd.add_block)
            bits_next = bits_reg + 64'd512;
        if (cmd.comp_start)
        begin
            v_next = h_reg;
            rnd_next = '0;
        end
        if (cmd.comp_round)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = wnew;
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.comp_final)
        begin
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];
        end
        if (cmd.out_shift)
        begin
            for (int i = 0; i < 7; i++)
                h_next[i] = h_reg[i + 1];
            h_next[7] = h_reg[0];
        end
        if (cmd.init_hash)
        begin
            for (int i = 0; i < 8; i++)
                h_next[i] = sha_iv(3'(i));
            pos_next = '0;
            bits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha_iv(3'(i));
            pos_reg <= '0;
            bits_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            h_reg <= h_next;
            pos_reg <= pos_next;
            bits_reg <= bits_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

endmodule

FILE: design/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer for absorb, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_command,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_index,
    input  sha256_pkg::sha_status_t  status,
    output sha256_pkg::sha_cmd_t     cmd
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       fin_reg, fin_next;   // compression belongs to a finish
    logic       two_reg, two_next;   // a second, length-only block follows
    logic [2:0] idx_reg, idx_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next = fin_reg;
        two_next = two_reg;
        idx_next = idx_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_ABSORB)
                    begin
                        cmd.put_byte = 1'b1;
                        if (status.pos == 6'd63)
                        begin
                            cmd.comp_start = 1'b1;
                            fin_next = 1'b0;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        cmd.put_byte = 1'b1;
                        cmd.use_pad = 1'b1;
                        cmd.clear_tail = 1'b1;
                        fin_next = 1'b1;
                        if (status.pos >= 6'd56)
                        begin
                            two_next = 1'b1;
                            cmd.comp_start = 1'b1;
                            state_next = ST_ROUND;
                        end
                        else
                        begin
                            two_next = 1'b0;
                            state_next = ST_LEN;
                        end
                    end
                end
            end
            ST_LEN:
            begin
                // pos still holds the tail length from before the pad byte
                cmd.put_length = 1'b1;
                cmd.comp_start = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.comp_round = 1'b1;
                if (status.round_last)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.comp_final = 1'b1;
                if (!fin_reg)
                begin
                    cmd.add_block = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (two_reg)
                begin
                    two_next = 1'b0;
                    cmd.clear_all = 1'b1;
                    state_next = ST_LEN;
                end
                else
                begin
                    idx_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.init_hash = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
            two_reg <= two_next;
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: design/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// SHA-256 over a byte stream with digest word output
// ----------------------------------------------------------------------------
// An absorb item is taken while idle; the 64th byte of a block then starts
// the compression (one round per cycle in a single shared round unit, plus
// the final add; the load happens in the accepting cycle). A finish pads and
// compresses, with a second block when 56 or more bytes are buffered, then
// offers the eight digest words one per cycle while out_ready is high, word 0
// first; the next item is taken once word 7 has gone. The hash then restarts.
module sha256_message_hasher_core (
    input  logic         clk,
    input  logic         rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    sha_cmd_t    cmd;
    sha_status_t status;
    logic [2:0]  idx;
    sha_status_t dp_status;

    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_index  (idx),
        .status     (status),
        .cmd        (cmd)
    );

    sha256_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_byte     (in_ch.message_byte),
        .status      (dp_status),
        .digest_word (out_ch.digest_word)
    );

    assign status = dp_status;
    assign out_ch.word_index = idx;
    assign out_ch.last_word = (idx == 3'd7);

endmodule
